/* design/frsa_pkg.sv */
// Package: transfer item types, op and status codes, and the default pool size.
`default_nettype none
package frsa_pkg;

    // Default number of slots in the pool
    localparam int unsigned POOL_SLOTS_DEF = 256;

    // Request op codes
    localparam logic [1:0] OP_ALLOC     = 2'd0;
    localparam logic [1:0] OP_TRY_ALLOC = 2'd1;
    localparam logic [1:0] OP_DEALLOC   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Request item
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] release_slot;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] granted_slot;
        logic [1:0] status;
    } t_out_item;

endpackage
`default_nettype wire

/* design/fifo_recycling_slot_allocator_unit.sv */
// Top level: slot allocator with a FIFO free list and an in-use bitmap in memories.
// Flow: a request transfer enters the execute state; its result is registered
//   on commit, which waits while an earlier result is still stalled at the
//   output. No new request is taken until commit; each request reads the queue
//   and bitmap memories at its transfer and writes them back at its commit.
// Reset: control registers cleared, no clearing pass; bitmap entries at or
//   above the fresh count are treated as clear, so the bitmap memory needs
//   no initialization.
`default_nettype none
module fifo_recycling_slot_allocator_unit #(
    parameter int unsigned POOL_SLOTS = frsa_pkg::POOL_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire frsa_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output frsa_pkg::t_out_item     o_out_data
);
    import frsa_pkg::*;

    localparam int unsigned SW = $clog2(POOL_SLOTS);
    localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
    localparam logic [CW-1:0] POOL_C   = CW'(POOL_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SLOTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Memories
    logic [SW-1:0] r_queue_mem [POOL_SLOTS];
    logic          r_map_mem   [POOL_SLOTS];
    logic [SW-1:0] r_q_rdata;
    logic          r_map_rdata;

    // Control and request registers
    logic          r_state, n_state;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [1:0]    r_op;
    logic [7:0]    r_rel;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_data, n_out_data;

    logic          in_accept;
    logic          out_accept;
    logic          commit;
    logic [SW-1:0] rel_idx;
    logic          rel_in_use;
    logic          map_we;
    logic [SW-1:0] map_waddr;
    logic          map_wdata;
    logic          q_we;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign commit      = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Release slot qualified by range and by the fresh count
    assign rel_idx    = SW'(r_rel);
    assign rel_in_use = (32'(r_rel) < POOL_SLOTS) && (CW'(rel_idx) < r_fresh) && r_map_rdata;

    // Read-modify-write decision for one request
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        map_we      = 1'b0;
        map_waddr   = rel_idx;
        map_wdata   = 1'b0;
        q_we        = 1'b0;

        if (out_accept) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = '{granted_slot: 8'd0, status: ST_OK};
                    if ((r_op == OP_ALLOC) || (r_op == OP_TRY_ALLOC)) begin
                        if (r_count != '0) begin
                            // Take the oldest freed slot
                            n_head    = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                            n_count   = r_count - 1'b1;
                            map_we    = 1'b1;
                            map_waddr = r_q_rdata;
                            map_wdata = 1'b1;
                            n_out_data.granted_slot = 8'(r_q_rdata);
                        end else if (r_op == OP_TRY_ALLOC) begin
                            n_out_data.status = ST_EMPTY;
                        end else if (r_fresh < POOL_C) begin
                            // Create a fresh slot
                            n_fresh   = r_fresh + 1'b1;
                            map_we    = 1'b1;
                            map_waddr = SW'(r_fresh);
                            map_wdata = 1'b1;
                            n_out_data.granted_slot = 8'(r_fresh);
                        end else begin
                            n_out_data.status = ST_EXHAUSTED;
                        end
                    end else if (r_op == OP_DEALLOC) begin
                        if (!rel_in_use) begin
                            n_out_data.status = ST_NOT_ALLOC;
                        end else begin
                            map_we    = 1'b1;
                            map_waddr = rel_idx;
                            map_wdata = 1'b0;
                            if (r_count < POOL_C) begin
                                q_we    = 1'b1;
                                n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (in_accept) begin
            r_op  <= i_in_data.op;
            r_rel <= i_in_data.release_slot;
        end
    end

    // Free queue memory: read at head on transfer, write at tail on release
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_q_rdata <= r_queue_mem[r_head];
        end
        if (q_we) begin
            r_queue_mem[r_tail] <= rel_idx;
        end
    end

    // In-use bitmap memory: read at the release slot on transfer
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_map_rdata <= r_map_mem[SW'(i_in_data.release_slot)];
        end
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
    end

    // Checks
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= POOL_C)
        else $error("fresh count beyond pool size");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fresh)
        else $error("free queue holds more slots than were created");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EXEC))
        else $error("request transfer did not start execution");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == ST_EXEC))
        else $error("result appeared without an executed request");

endmodule
`default_nettype wire
